// ===== hdl/utf8_decoder_assert.svh =====
// assertion macros for the utf8 decoder
`ifndef UTF8_DECODER_ASSERT_SVH
`define UTF8_DECODER_ASSERT_SVH

// condition implies consequence in the same cycle
`define UTF8D_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define UTF8D_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/utf8d_pkg.sv =====
// shared types and constants for the utf8 decoder
package utf8d_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [20:0] MaxCode = 21'h10FFFF;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_PARTIAL = 2'd2;

  typedef enum logic [2:0] {
    CLS_PLAIN = 3'd0,
    CLS_E0    = 3'd1,
    CLS_ED    = 3'd2,
    CLS_F0    = 3'd3,
    CLS_F4    = 3'd4
  } cls_t;

  typedef enum logic [1:0] {
    MODE_LEAD,
    MODE_CONT,
    MODE_SKIP
  } mode_t;

  typedef struct packed {
    logic [7:0] byte_v;
    logic       last;
    logic       is_ascii;
    logic       lead_bad;
    logic [1:0] len;
    cls_t       cls;
    logic [6:0] lead_bits;
    logic       cont_plain;
    logic       chk_e0;
    logic       chk_ed;
    logic       chk_f0;
    logic       chk_f4;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hdl/utf8d_front.sv =====
// front end: accepts bytes and classifies them for the queue
module utf8d_front (
  input  logic                 in_valid,
  input  logic [7:0]           in_byte_in,
  input  logic                 in_last_byte,
  output logic                 in_stall,
  input  utf8d_pkg::q_status_t q_status,
  output logic                 push,
  output utf8d_pkg::item_t     push_item
);

  logic [7:0] c;

  assign c        = in_byte_in;
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    push_item            = '0;
    push_item.byte_v     = c;
    push_item.last       = in_last_byte;
    push_item.is_ascii   = (c < 8'h80);
    push_item.lead_bad   = (c >= 8'h80) && ((c < 8'hC2) || (c >= 8'hF5));
    push_item.cont_plain = (c[7:6] == 2'b10);
    push_item.chk_e0     = (c[7:5] == 3'b101);
    push_item.chk_ed     = (c[7:5] == 3'b100);
    push_item.chk_f0     = (c >= 8'h90) && (c <= 8'hBF);
    push_item.chk_f4     = (c[7:4] == 4'b1000);
    push_item.cls        = utf8d_pkg::CLS_PLAIN;
    if (c < 8'hE0) begin
      push_item.len       = 2'd1;
      push_item.lead_bits = {2'b00, c[4:0]};
    end else if (c < 8'hF0) begin
      push_item.len       = 2'd2;
      push_item.lead_bits = {3'b000, c[3:0]};
      if (c == 8'hE0) push_item.cls = utf8d_pkg::CLS_E0;
      else if (c == 8'hED) push_item.cls = utf8d_pkg::CLS_ED;
    end else begin
      push_item.len       = 2'd3;
      push_item.lead_bits = {4'b0000, c[2:0]};
      if (c == 8'hF0) push_item.cls = utf8d_pkg::CLS_F0;
      else if (c == 8'hF4) push_item.cls = utf8d_pkg::CLS_F4;
    end
  end

endmodule

// ===== hdl/utf8d_queue.sv =====
// small queue of classified items between front and back
module utf8d_queue #(
  parameter int unsigned DEPTH = utf8d_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  utf8d_pkg::item_t     push_item,
  input  logic                 pop,
  output utf8d_pkg::item_t     head_item,
  output utf8d_pkg::q_status_t q_status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  utf8d_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_status.full  = (count_r == CW'(DEPTH));
  assign q_status.empty = (count_r == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head_item      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop) rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== hdl/utf8d_back.sv =====
// back end: sequence state, code point assembly and result register
module utf8d_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  utf8d_pkg::item_t     head_item,
  input  utf8d_pkg::q_status_t q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [20:0]          out_code_point,
  output logic [1:0]           out_status,
  output logic                 out_end_of_string
);

  utf8d_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]       rem_r, rem_nxt;
  utf8d_pkg::cls_t  cls_r, cls_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic [20:0]      acc_r, acc_nxt;
  logic             perr_r, perr_nxt;

  logic             out_valid_r;
  logic [20:0]      cp_r;
  logic [1:0]       status_r;
  logic             eos_r;

  logic             emit;
  logic [20:0]      emit_cp;
  logic [1:0]       emit_status;
  logic             emit_eos;

  logic             cont_ok;
  logic [20:0]      acc_shift;
  logic [1:0]       rem_dec;
  logic             seq_bad;

  assign pop       = !q_status.empty && (!out_valid_r || !out_stall);
  assign acc_shift = {acc_r[14:0], head_item.byte_v[5:0]};
  assign rem_dec   = rem_r - 2'd1;
  assign seq_bad   = perr_r || !cont_ok || (acc_shift > utf8d_pkg::MaxCode);

  always_comb begin
    cont_ok = head_item.cont_plain;
    if (pos_r == 2'd1) begin
      unique case (cls_r)
        utf8d_pkg::CLS_E0: cont_ok = head_item.chk_e0;
        utf8d_pkg::CLS_ED: cont_ok = head_item.chk_ed;
        utf8d_pkg::CLS_F0: cont_ok = head_item.chk_f0;
        utf8d_pkg::CLS_F4: cont_ok = head_item.chk_f4;
        default:           cont_ok = head_item.cont_plain;
      endcase
    end
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    if (pop) begin
      unique case (mode_r)
        utf8d_pkg::MODE_SKIP: begin
          if (head_item.last) mode_nxt = utf8d_pkg::MODE_LEAD;
        end
        utf8d_pkg::MODE_LEAD: begin
          if (head_item.is_ascii) mode_nxt = utf8d_pkg::MODE_LEAD;
          else if (head_item.lead_bad)
            mode_nxt = head_item.last ? utf8d_pkg::MODE_LEAD : utf8d_pkg::MODE_SKIP;
          else if (!head_item.last) mode_nxt = utf8d_pkg::MODE_CONT;
        end
        utf8d_pkg::MODE_CONT: begin
          if (rem_dec == 2'd0) begin
            if (seq_bad && !head_item.last) mode_nxt = utf8d_pkg::MODE_SKIP;
            else mode_nxt = utf8d_pkg::MODE_LEAD;
          end else if (head_item.last) begin
            mode_nxt = utf8d_pkg::MODE_LEAD;
          end
        end
        default: mode_nxt = utf8d_pkg::MODE_LEAD;
      endcase
    end
  end

  // sequence datapath and result
  always_comb begin
    rem_nxt     = rem_r;
    cls_nxt     = cls_r;
    pos_nxt     = pos_r;
    acc_nxt     = acc_r;
    perr_nxt    = perr_r;
    emit        = 1'b0;
    emit_cp     = '0;
    emit_status = utf8d_pkg::STATUS_OK;
    emit_eos    = 1'b1;
    if (pop) begin
      unique case (mode_r)
        utf8d_pkg::MODE_SKIP: begin
        end
        utf8d_pkg::MODE_LEAD: begin
          if (head_item.is_ascii) begin
            emit     = 1'b1;
            emit_cp  = {13'd0, head_item.byte_v};
            emit_eos = head_item.last;
          end else if (head_item.lead_bad) begin
            emit        = 1'b1;
            emit_status = utf8d_pkg::STATUS_INVALID;
          end else if (head_item.last) begin
            emit        = 1'b1;
            emit_status = utf8d_pkg::STATUS_PARTIAL;
          end else begin
            rem_nxt  = head_item.len;
            cls_nxt  = head_item.cls;
            pos_nxt  = 2'd1;
            acc_nxt  = {14'd0, head_item.lead_bits};
            perr_nxt = 1'b0;
          end
        end
        utf8d_pkg::MODE_CONT: begin
          rem_nxt  = rem_dec;
          pos_nxt  = pos_r + 2'd1;
          acc_nxt  = acc_shift;
          perr_nxt = perr_r || !cont_ok;
          if (rem_dec == 2'd0) begin
            emit = 1'b1;
            if (seq_bad) begin
              emit_status = utf8d_pkg::STATUS_INVALID;
            end else begin
              emit_cp  = acc_shift;
              emit_eos = head_item.last;
            end
          end else if (head_item.last) begin
            emit        = 1'b1;
            emit_status = utf8d_pkg::STATUS_PARTIAL;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= utf8d_pkg::MODE_LEAD;
      rem_r       <= '0;
      cls_r       <= utf8d_pkg::CLS_PLAIN;
      pos_r       <= '0;
      acc_r       <= '0;
      perr_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      rem_r  <= rem_nxt;
      cls_r  <= cls_nxt;
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      perr_r <= perr_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cp_r     <= emit_cp;
      status_r <= emit_status;
      eos_r    <= emit_eos;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_point    = cp_r;
  assign out_status        = status_r;
  assign out_end_of_string = eos_r;

endmodule

// ===== hdl/utf8_decoder.sv =====
// top level of the utf8 to utf32 decoder
// Takes one UTF-8 byte per cycle and gives a 21-bit code point for each
// finished sequence, or an error/partial status with end_of_string set.
// A byte is classified on entry and written into a small queue (QUEUE_DEPTH
// items). While its result is not stalled, the back end takes one item per
// cycle from the queue head and registers its result at that same edge. A
// byte thus passes the queue and then the result register before its result
// can be taken. Sustained rate is one byte per cycle while the output is not
// stalled, as the back end updates its sequence state for each byte. A
// stalled result holds the back end, and the input stalls once the queue is
// full. The input is free again the cycle after the back end next takes an
// item. After an error the bytes up to the end mark give no result.
`include "utf8_decoder_assert.svh"

module utf8_decoder #(
  parameter int unsigned QUEUE_DEPTH = utf8d_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_code_point,
  output logic [1:0]  out_status,
  output logic        out_end_of_string
);

  utf8d_pkg::q_status_t q_status;
  utf8d_pkg::item_t     push_item;
  utf8d_pkg::item_t     head_item;
  logic                 push;
  logic                 pop;

  utf8d_front u_front (
    .in_valid     (in_valid),
    .in_byte_in   (in_byte_in),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .q_status     (q_status),
    .push         (push),
    .push_item    (push_item)
  );

  utf8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_status  (q_status)
  );

  utf8d_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_item         (head_item),
    .q_status          (q_status),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_code_point    (out_code_point),
    .out_status        (out_status),
    .out_end_of_string (out_end_of_string)
  );

  `UTF8D_ASSERT_NOW(a_err_zero_cp, out_valid && (out_status != utf8d_pkg::STATUS_OK), out_code_point == 21'd0, "error result with nonzero code point")
  `UTF8D_ASSERT_NOW(a_err_eos, out_valid && (out_status != utf8d_pkg::STATUS_OK), out_end_of_string, "error result without end mark")
  `UTF8D_ASSERT_NOW(a_queue_sane, 1'b1, !(q_status.full && q_status.empty), "queue full and empty at once")
  `UTF8D_ASSERT_NEXT(a_pop_gives_item, push && q_status.empty, !q_status.empty, "pushed item lost from empty queue")

endmodule
